### rtl/kjs_pkg.sv
package kjs_pkg;

	// Table size and field widths
	localparam int MAX_KEYS      = 16;
	localparam int DURATION_BITS = 16;
	localparam int IDX_W         = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
	localparam int CNT_W         = $clog2(MAX_KEYS + 1);
	localparam int TOTAL_W       = DURATION_BITS + $clog2(MAX_KEYS);
	localparam int POS_W         = 12;
	localparam int DUR_IN_W      = 16;
	localparam int TIME_W        = 31;
	localparam int DIFF_W        = TIME_W + 1;
	localparam int PROD_W        = DURATION_BITS + POS_W;
	localparam int SEG_W         = 4;
	localparam int ACT_W         = 2;
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = 32;
	localparam int MOD_CNT_W     = $clog2(DIFF_W);
	localparam int BL_CNT_W      = $clog2(PROD_W);

	// Action codes
	localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd0;
	localparam logic [ACT_W-1:0] ACT_ADD   = 2'd1;
	localparam logic [ACT_W-1:0] ACT_POSE  = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_TIME_OFFSET = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_REVERSE     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_INTERP      = 2'd2;

	// Joint select for the shared blend unit
	localparam logic [1:0] JOINT_KNEE  = 2'd0;
	localparam logic [1:0] JOINT_FEMUR = 2'd1;
	localparam logic [1:0] JOINT_HIP   = 2'd2;

	typedef struct packed {
		logic [ACT_W-1:0]    action;
		logic [POS_W-1:0]    knee_value;
		logic [POS_W-1:0]    femur_value;
		logic [POS_W-1:0]    hip_value;
		logic [DUR_IN_W-1:0] duration_ms;
		logic [TIME_W-1:0]   now_ms;
	} in_item_t;

	typedef struct packed {
		logic [POS_W-1:0] knee_out;
		logic [POS_W-1:0] femur_out;
		logic [POS_W-1:0] hip_out;
		logic [SEG_W-1:0] segment;
	} out_item_t;

	typedef struct packed {
		logic [POS_W-1:0]         knee;
		logic [POS_W-1:0]         femur;
		logic [POS_W-1:0]         hip;
		logic [DURATION_BITS-1:0] dur;
	} key_entry_t;

	typedef struct packed {
		logic [DURATION_BITS-1:0] phase;
		logic [DURATION_BITS-1:0] dur;
		logic [POS_W-1:0]         cur;
		logic [POS_W-1:0]         nxt;
	} blend_req_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MOD,
		ST_FIX,
		ST_WALK_RD,
		ST_WALK_CMP,
		ST_NXT_RD,
		ST_NXT_LD,
		ST_BLEND_GO,
		ST_BLEND_WAIT,
		ST_EMIT
	} seq_state_t;

	typedef enum logic [1:0] {
		BL_IDLE,
		BL_MUL,
		BL_DIV,
		BL_DONE
	} blend_state_t;

endpackage

### rtl/kjs_blend.sv
module kjs_blend (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                go,
	input  kjs_pkg::blend_req_t                 req,
	output logic                                done,
	output logic [kjs_pkg::POS_W-1:0]           value
);

	localparam int PW = kjs_pkg::PROD_W;
	localparam int DW = kjs_pkg::DURATION_BITS;
	localparam int XW = kjs_pkg::POS_W;

	kjs_pkg::blend_state_t state_q, state_d;

	logic [kjs_pkg::BL_CNT_W-1:0] cnt_q;
	logic [DW-1:0]                phase_q;
	logic [DW-1:0]                dur_q;
	logic [XW-1:0]                cur_q;
	logic                         neg_q;
	logic [XW-1:0]                mag_q;
	logic [PW-1:0]                acc_q;
	logic [DW-1:0]                rem_q;

	logic [XW:0]   diff;
	logic [PW-1:0] acc_add;
	logic [DW:0]   trial;
	logic          qbit;
	logic [XW-1:0] quot;

	// Signed difference toward the next keyframe
	assign diff = {1'b0, req.nxt} - {1'b0, req.cur};

	// Shift-and-add step, one multiplier bit per cycle
	assign acc_add = {acc_q[PW-2:0], 1'b0} + (mag_q[XW-1] ? PW'(phase_q) : '0);

	// Restoring division step, one quotient bit per cycle
	assign trial = {rem_q, acc_q[PW-1]};
	assign qbit  = (trial >= {1'b0, dur_q});
	assign quot  = acc_q[XW-1:0];

	// Quotient never exceeds the magnitude of the difference
	assign value = neg_q ? (cur_q - quot) : (cur_q + quot);
	assign done  = (state_q == kjs_pkg::BL_DONE);

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= kjs_pkg::BL_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			kjs_pkg::BL_IDLE: begin
				if (go) begin
					state_d = kjs_pkg::BL_MUL;
				end
			end
			kjs_pkg::BL_MUL: begin
				if (cnt_q == '0) begin
					state_d = kjs_pkg::BL_DIV;
				end
			end
			kjs_pkg::BL_DIV: begin
				if (cnt_q == '0) begin
					state_d = kjs_pkg::BL_DONE;
				end
			end
			kjs_pkg::BL_DONE: begin
				state_d = kjs_pkg::BL_IDLE;
			end
			default: begin
				state_d = kjs_pkg::BL_IDLE;
			end
		endcase
	end

	// Datapath: multiply phase by |diff|, then divide by duration
	always_ff @(posedge clk) begin
		case (state_q)
			kjs_pkg::BL_IDLE: begin
				if (go) begin
					phase_q <= req.phase;
					dur_q   <= req.dur;
					cur_q   <= req.cur;
					neg_q   <= diff[XW];
					mag_q   <= diff[XW] ? XW'(-diff) : diff[XW-1:0];
					acc_q   <= '0;
					cnt_q   <= kjs_pkg::BL_CNT_W'(XW - 1);
				end
			end
			kjs_pkg::BL_MUL: begin
				acc_q <= acc_add;
				mag_q <= {mag_q[XW-2:0], 1'b0};
				if (cnt_q == '0) begin
					rem_q <= '0;
					cnt_q <= kjs_pkg::BL_CNT_W'(PW - 1);
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
			kjs_pkg::BL_DIV: begin
				rem_q <= qbit ? DW'(trial - {1'b0, dur_q}) : trial[DW-1:0];
				acc_q <= {acc_q[PW-2:0], qbit};
				cnt_q <= cnt_q - 1'b1;
			end
			default: begin
			end
		endcase
	end

endmodule

### rtl/keyframe_joint_sequencer_core.sv
// Channel   | Ports                                   | Handshake
// ----------+-----------------------------------------+--------------------------------
// command   | start, busy, cmd                        | taken when start && !busy
// result    | result_valid, result                    | one-cycle strobe, no backpressure
// config    | cfg_valid, cfg_ready, cfg_index, cfg_data | written when valid && ready
//
// Clear and add never raise busy. A pose holds busy through the bit-serial modulo,
// the fix step, the segment walk and the next-keyframe read and load, plus the shared
// bit-serial multiply/divide for each joint when interpolating, and the emit.
// A pose on an empty loop or past every segment ends with no result.
// Reset is asynchronous and clears control state; the keyframe memory is not cleared.
// The result strobe cannot be stalled; config is always ready.
module keyframe_joint_sequencer_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  kjs_pkg::in_item_t                  cmd,
	output logic                               result_valid,
	output kjs_pkg::out_item_t                 result,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [kjs_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [kjs_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int TW = kjs_pkg::TOTAL_W;
	localparam int DW = kjs_pkg::DIFF_W;

	kjs_pkg::seq_state_t state_q, state_d;

	// Configuration
	logic [kjs_pkg::TIME_W-1:0] offset_q;
	logic                       reverse_q;
	logic                       interp_q;

	// Table bookkeeping
	logic [kjs_pkg::CNT_W-1:0] count_q;
	logic [TW-1:0]             total_q;

	// Keyframe memory
	kjs_pkg::key_entry_t key_mem [kjs_pkg::MAX_KEYS];
	kjs_pkg::key_entry_t rd_q;
	logic [kjs_pkg::IDX_W-1:0] rd_addr;

	// Pose working registers
	logic [DW-1:0]                 sh_q;
	logic [TW-1:0]                 rem_q;
	logic                          neg_q;
	logic [kjs_pkg::MOD_CNT_W-1:0] mcnt_q;
	logic [TW-1:0]                 phase_q;
	logic [kjs_pkg::CNT_W-1:0]     idx_q;
	kjs_pkg::key_entry_t           cur_q;
	kjs_pkg::key_entry_t           nxt_q;
	logic [1:0]                    joint_q;
	kjs_pkg::out_item_t            out_q;

	logic                      accept;
	logic                      do_add;
	logic [DW-1:0]             d_pos;
	logic [DW-1:0]             d_neg;
	logic [TW:0]               trial;
	logic                      trial_ge;
	logic                      flip;
	logic [kjs_pkg::CNT_W-1:0] nidx;
	logic                      blend_go;
	kjs_pkg::blend_req_t       blend_req;
	logic                      blend_done;
	logic [kjs_pkg::POS_W-1:0] blend_value;
	kjs_pkg::key_entry_t       wr_entry;

	assign accept    = start && !busy;
	assign do_add    = accept && (cmd.action == kjs_pkg::ACT_ADD)
	                   && (count_q < kjs_pkg::CNT_W'(kjs_pkg::MAX_KEYS));
	assign cfg_ready = 1'b1;

	assign wr_entry.knee  = cmd.knee_value;
	assign wr_entry.femur = cmd.femur_value;
	assign wr_entry.hip   = cmd.hip_value;
	assign wr_entry.dur   = kjs_pkg::DURATION_BITS'(cmd.duration_ms);

	// Signed time difference as sign and magnitude
	assign d_pos = DW'(cmd.now_ms) - DW'(offset_q);
	assign d_neg = DW'(offset_q) - DW'(cmd.now_ms);

	// Restoring modulo step, one dividend bit per cycle
	assign trial    = {rem_q, sh_q[DW-1]};
	assign trial_ge = (trial >= {1'b0, total_q});

	// Negative remainder repair and mirroring fold into one subtract
	assign flip = (neg_q && (rem_q != '0)) ^ reverse_q;

	// Next keyframe wraps to the first
	assign nidx = idx_q + 1'b1;

	// Operands for the current joint
	always_comb begin
		blend_req.phase = kjs_pkg::DURATION_BITS'(phase_q);
		blend_req.dur   = cur_q.dur;
		case (joint_q)
			kjs_pkg::JOINT_KNEE: begin
				blend_req.cur = cur_q.knee;
				blend_req.nxt = nxt_q.knee;
			end
			kjs_pkg::JOINT_FEMUR: begin
				blend_req.cur = cur_q.femur;
				blend_req.nxt = nxt_q.femur;
			end
			default: begin
				blend_req.cur = cur_q.hip;
				blend_req.nxt = nxt_q.hip;
			end
		endcase
	end

	kjs_blend u_blend (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (blend_go),
		.req    (blend_req),
		.done   (blend_done),
		.value  (blend_value)
	);

	assign result = out_q;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= kjs_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and outputs
	always_comb begin
		state_d      = state_q;
		busy         = 1'b1;
		result_valid = 1'b0;
		blend_go     = 1'b0;
		rd_addr      = idx_q[kjs_pkg::IDX_W-1:0];
		case (state_q)
			kjs_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (accept && (cmd.action == kjs_pkg::ACT_POSE) && (total_q != '0)) begin
					state_d = kjs_pkg::ST_MOD;
				end
			end
			kjs_pkg::ST_MOD: begin
				if (mcnt_q == '0) begin
					state_d = kjs_pkg::ST_FIX;
				end
			end
			kjs_pkg::ST_FIX: begin
				state_d = kjs_pkg::ST_WALK_RD;
			end
			kjs_pkg::ST_WALK_RD: begin
				if (idx_q == count_q) begin
					state_d = kjs_pkg::ST_IDLE;
				end else begin
					state_d = kjs_pkg::ST_WALK_CMP;
				end
			end
			kjs_pkg::ST_WALK_CMP: begin
				if (phase_q < TW'(rd_q.dur)) begin
					state_d = kjs_pkg::ST_NXT_RD;
				end else begin
					state_d = kjs_pkg::ST_WALK_RD;
				end
			end
			kjs_pkg::ST_NXT_RD: begin
				rd_addr = (nidx < count_q) ? nidx[kjs_pkg::IDX_W-1:0] : '0;
				state_d = kjs_pkg::ST_NXT_LD;
			end
			kjs_pkg::ST_NXT_LD: begin
				state_d = interp_q ? kjs_pkg::ST_BLEND_GO : kjs_pkg::ST_EMIT;
			end
			kjs_pkg::ST_BLEND_GO: begin
				blend_go = 1'b1;
				state_d  = kjs_pkg::ST_BLEND_WAIT;
			end
			kjs_pkg::ST_BLEND_WAIT: begin
				if (blend_done) begin
					state_d = (joint_q == kjs_pkg::JOINT_HIP) ? kjs_pkg::ST_EMIT
					                                         : kjs_pkg::ST_BLEND_GO;
				end
			end
			kjs_pkg::ST_EMIT: begin
				result_valid = 1'b1;
				state_d      = kjs_pkg::ST_IDLE;
			end
			default: begin
				state_d = kjs_pkg::ST_IDLE;
			end
		endcase
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q  <= '0;
			reverse_q <= 1'b0;
			interp_q  <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				kjs_pkg::CFG_TIME_OFFSET: offset_q  <= cfg_data[kjs_pkg::TIME_W-1:0];
				kjs_pkg::CFG_REVERSE:     reverse_q <= cfg_data[0];
				kjs_pkg::CFG_INTERP:      interp_q  <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// Table count and loop length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			total_q <= '0;
		end else if (accept && (cmd.action == kjs_pkg::ACT_CLEAR)) begin
			count_q <= '0;
			total_q <= '0;
		end else if (do_add) begin
			count_q <= count_q + 1'b1;
			total_q <= total_q + TW'(wr_entry.dur);
		end
	end

	// Keyframe memory write and registered read
	always_ff @(posedge clk) begin
		if (do_add) begin
			key_mem[count_q[kjs_pkg::IDX_W-1:0]] <= wr_entry;
		end
		rd_q <= key_mem[rd_addr];
	end

	// Pose datapath
	always_ff @(posedge clk) begin
		case (state_q)
			kjs_pkg::ST_IDLE: begin
				neg_q  <= d_pos[DW-1];
				sh_q   <= d_pos[DW-1] ? d_neg : d_pos;
				rem_q  <= '0;
				mcnt_q <= kjs_pkg::MOD_CNT_W'(DW - 1);
			end
			kjs_pkg::ST_MOD: begin
				rem_q  <= trial_ge ? TW'(trial - {1'b0, total_q}) : trial[TW-1:0];
				sh_q   <= {sh_q[DW-2:0], 1'b0};
				mcnt_q <= mcnt_q - 1'b1;
			end
			kjs_pkg::ST_FIX: begin
				phase_q <= flip ? (total_q - rem_q) : rem_q;
				idx_q   <= '0;
			end
			kjs_pkg::ST_WALK_CMP: begin
				if (phase_q < TW'(rd_q.dur)) begin
					cur_q <= rd_q;
				end else begin
					phase_q <= phase_q - TW'(rd_q.dur);
					idx_q   <= idx_q + 1'b1;
				end
			end
			kjs_pkg::ST_NXT_LD: begin
				nxt_q             <= rd_q;
				joint_q           <= kjs_pkg::JOINT_KNEE;
				out_q.knee_out    <= cur_q.knee;
				out_q.femur_out   <= cur_q.femur;
				out_q.hip_out     <= cur_q.hip;
				out_q.segment     <= kjs_pkg::SEG_W'(idx_q);
			end
			kjs_pkg::ST_BLEND_WAIT: begin
				if (blend_done) begin
					joint_q <= joint_q + 1'b1;
					case (joint_q)
						kjs_pkg::JOINT_KNEE:  out_q.knee_out  <= blend_value;
						kjs_pkg::JOINT_FEMUR: out_q.femur_out <= blend_value;
						default:              out_q.hip_out   <= blend_value;
					endcase
				end
			end
			default: begin
			end
		endcase
	end

endmodule

### tb/tb_keyframe_joint_sequencer_core.sv
`timescale 1ns / 100ps

module tb_keyframe_joint_sequencer_core;
	import kjs_pkg::*;

	localparam int CYCLE_LIMIT   = 1_000_000;
	localparam int SETTLE_CYCLES = 250;
	localparam int REPORT_LIMIT  = 10;
	localparam int PHASE_ITEMS   = 64;

	// Action code with no meaning to the block
	localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

	logic                  clk          = 1'b0;
	logic                  arst_n       = 1'b0;
	logic                  start        = 1'b0;
	logic                  busy;
	in_item_t              cmd          = '0;
	logic                  result_valid;
	out_item_t             result;
	logic                  cfg_valid    = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index    = CFG_TIME_OFFSET;
	logic [CFG_DATA_W-1:0] cfg_data     = '0;

	// Mirror of the keyframe loop and the registers
	logic [POS_W-1:0]         knee_mem  [MAX_KEYS];
	logic [POS_W-1:0]         femur_mem [MAX_KEYS];
	logic [POS_W-1:0]         hip_mem   [MAX_KEYS];
	logic [DURATION_BITS-1:0] dur_mem   [MAX_KEYS];
	int                       key_count  = 0;
	longint                   loop_total = 0;
	logic [TIME_W-1:0]        mir_offset  = '0;
	bit                       mir_reverse = 1'b0;
	bit                       mir_interp  = 1'b0;

	out_item_t expected_poses[$];
	out_item_t pose_want;
	int        mismatch_count = 0;
	int        cycle_count    = 0;
	int        idle_pct       = 0;
	int        applied_items  = 0;

	keyframe_joint_sequencer_core DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.cmd          (cmd),
		.result_valid (result_valid),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Linear blend of one joint toward the next keyframe, truncating toward zero
	function automatic logic [POS_W-1:0] blend_joint(logic [POS_W-1:0] cur,
			logic [POS_W-1:0] nxt, longint phase, longint seg_dur);
		longint diff;
		longint v;
		if (!mir_interp)
			return cur;
		diff = longint'(nxt) - longint'(cur);
		v = longint'(cur) + (phase * diff) / seg_dur;
		return v[POS_W-1:0];
	endfunction

	// Apply one command to the mirror and work out the pose it yields
	function automatic void predict_command(input in_item_t c, output bit has_pose,
			output out_item_t pose, output bit applied);
		longint d;
		longint phase;
		longint seg_dur;
		int     nxt;
		has_pose = 1'b0;
		pose     = '0;
		applied  = 1'b1;
		case (c.action)
			ACT_CLEAR: begin
				key_count  = 0;
				loop_total = 0;
			end
			ACT_ADD: begin
				if (key_count >= MAX_KEYS) begin
					applied = 1'b0;
				end else begin
					knee_mem[key_count]  = c.knee_value;
					femur_mem[key_count] = c.femur_value;
					hip_mem[key_count]   = c.hip_value;
					dur_mem[key_count]   = c.duration_ms[DURATION_BITS-1:0];
					loop_total += longint'(c.duration_ms[DURATION_BITS-1:0]);
					key_count++;
				end
			end
			ACT_POSE: begin
				if (loop_total != 0) begin
					d = longint'(c.now_ms) - longint'(mir_offset);
					phase = d % loop_total;
					if (phase < 0)
						phase += loop_total;
					if (mir_reverse)
						phase = loop_total - phase;
					// Walk the segments to the one that holds the phase
					for (int i = 0; i < key_count && !has_pose; i++) begin
						seg_dur = longint'(dur_mem[i]);
						if (phase < seg_dur) begin
							nxt = (i + 1 < key_count) ? i + 1 : 0;
							pose.knee_out  = blend_joint(knee_mem[i], knee_mem[nxt],
								phase, seg_dur);
							pose.femur_out = blend_joint(femur_mem[i], femur_mem[nxt],
								phase, seg_dur);
							pose.hip_out   = blend_joint(hip_mem[i], hip_mem[nxt],
								phase, seg_dur);
							pose.segment   = SEG_W'(i);
							has_pose = 1'b1;
						end else begin
							phase -= seg_dur;
						end
					end
				end
			end
			default: begin
				applied = 1'b0;
			end
		endcase
	endfunction

	task automatic report_mismatch(string what, out_item_t want, out_item_t got);
		if (mismatch_count < REPORT_LIMIT)
			$display("%0t %s: expected %0d/%0d/%0d seg %0d, got %0d/%0d/%0d seg %0d",
				$time, what, want.knee_out, want.femur_out, want.hip_out, want.segment,
				got.knee_out, got.femur_out, got.hip_out, got.segment);
		mismatch_count++;
	endtask

	// Check each result transaction against the oldest expected pose
	always @(posedge clk) begin
		if (arst_n && result_valid) begin
			if (expected_poses.size() == 0) begin
				report_mismatch("unexpected result", '0, result);
			end else begin
				pose_want = expected_poses.pop_front();
				if (result.knee_out !== pose_want.knee_out ||
						result.femur_out !== pose_want.femur_out ||
						result.hip_out !== pose_want.hip_out ||
						result.segment !== pose_want.segment)
					report_mismatch("pose mismatch", pose_want, result);
			end
		end
	end

	function automatic in_item_t make_cmd(logic [ACT_W-1:0] act, logic [POS_W-1:0] kn,
			logic [POS_W-1:0] fe, logic [POS_W-1:0] hi, logic [DUR_IN_W-1:0] dur,
			logic [TIME_W-1:0] now);
		in_item_t c;
		c.action      = act;
		c.knee_value  = kn;
		c.femur_value = fe;
		c.hip_value   = hi;
		c.duration_ms = dur;
		c.now_ms      = now;
		return c;
	endfunction

	// Send one command transaction; start stays high until the next one decides
	task automatic send_command(input in_item_t c);
		int        gap;
		bit        has_pose;
		bit        applied;
		out_item_t pose;
		gap = 0;
		if (idle_pct > 0 && $urandom_range(99) < idle_pct)
			gap = $urandom_range(1, 48);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		cmd   <= c;
		@(posedge clk);
		while (busy) @(posedge clk);
		predict_command(c, has_pose, pose, applied);
		if (has_pose)
			expected_poses.push_back(pose);
		if (applied)
			applied_items++;
	endtask

	// Hold the sender until every expected pose has come
	task automatic await_results();
		start <= 1'b0;
		@(posedge clk);
		while (expected_poses.size() != 0) @(posedge clk);
	endtask

	task automatic drain_block();
		await_results();
		while (busy) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			CFG_TIME_OFFSET: mir_offset  = data[TIME_W-1:0];
			CFG_REVERSE:     mir_reverse = data[0];
			CFG_INTERP:      mir_interp  = data[0];
			default: ;
		endcase
	endtask

	// Flag registers get random upper bits to show only bit 0 counts
	function automatic logic [CFG_DATA_W-1:0] flag_word(bit b);
		return ($urandom & ~32'd1) | CFG_DATA_W'(b);
	endfunction

	task automatic set_config(logic [CFG_DATA_W-1:0] offset, bit reverse, bit interp);
		drain_block();
		write_register(CFG_TIME_OFFSET, offset);
		write_register(CFG_REVERSE, flag_word(reverse));
		write_register(CFG_INTERP, flag_word(interp));
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [DUR_IN_W-1:0] random_duration();
		int r;
		r = $urandom_range(99);
		if (r < 8)
			return '0;
		if (r < 20)
			return DUR_IN_W'($urandom);
		return DUR_IN_W'($urandom_range(1, 40));
	endfunction

	function automatic in_item_t random_cmd(logic [ACT_W-1:0] act);
		return make_cmd(act, POS_W'($urandom), POS_W'($urandom), POS_W'($urandom),
			random_duration(), TIME_W'($urandom));
	endfunction

	// Reset defaults, empty loop, unknown action, field extremes and a full table
	task automatic test_directed_table();
		idle_pct = 0;
		send_command(random_cmd(ACT_POSE));
		send_command(make_cmd(ACT_UNUSED, '1, '1, '1, '1, '1));
		send_command(make_cmd(ACT_ADD, '1, '0, '1, '0, '1));
		send_command(make_cmd(ACT_ADD, '0, '1, '0, '1, '0));
		send_command(make_cmd(ACT_POSE, '0, '0, '0, '0, '1));
		send_command(make_cmd(ACT_POSE, '1, '1, '1, '1, '0));
		send_command(random_cmd(ACT_CLEAR));
		send_command(make_cmd(ACT_POSE, '0, '0, '0, '0, TIME_W'(100)));
		// Fill past the last slot; the final add must drop
		for (int i = 0; i <= MAX_KEYS; i++)
			send_command(make_cmd(ACT_ADD, (i % 2) ? '1 : '0, (i % 2) ? '0 : '1,
				POS_W'(i * 255), (i == 5) ? '1 : (i == 3) ? '0 : DUR_IN_W'(i + 1),
				TIME_W'($urandom)));
		send_command(random_cmd(ACT_POSE));
		send_command(random_cmd(ACT_POSE));
	endtask

	// Mirrored phase at zero, negative time difference and interpolation
	task automatic test_reverse_interp();
		set_config(32'd1000, 1'b1, 1'b1);
		send_command(make_cmd(ACT_POSE, '0, '0, '0, '0, TIME_W'(1000)));
		send_command(make_cmd(ACT_POSE, '0, '0, '0, '0, TIME_W'(1001)));
		send_command(make_cmd(ACT_POSE, '0, '0, '0, '0, '0));
		send_command(random_cmd(ACT_CLEAR));
		send_command(make_cmd(ACT_ADD, 12'd100, 12'd4000, 12'd2000, 16'd10, '0));
		send_command(make_cmd(ACT_ADD, 12'd4000, 12'd100, 12'd2000, 16'd7, '0));
		send_command(make_cmd(ACT_POSE, '0, '0, '0, '0, TIME_W'(1003)));
		await_results();
		for (int i = 0; i < 6; i++)
			send_command(make_cmd(ACT_POSE, '0, '0, '0, '0,
				TIME_W'(1000 + $urandom_range(0, 20))));
	endtask

	// Clear, add a few keyframes, then pose; sometimes a stray command instead
	task automatic run_burst();
		int n_keys;
		int n_poses;
		in_item_t c;
		if ($urandom_range(99) < 15) begin
			send_command(random_cmd(ACT_W'($urandom_range(0, 3))));
		end else begin
			n_keys  = ($urandom_range(99) < 10) ? $urandom_range(14, 18)
			                                    : $urandom_range(1, 6);
			n_poses = $urandom_range(2, 10);
			send_command(random_cmd(ACT_CLEAR));
			repeat (n_keys) send_command(random_cmd(ACT_ADD));
			repeat (n_poses) begin
				c = random_cmd(ACT_POSE);
				// Land near the offset to reach phase zero and its mirror
				if ($urandom_range(99) < 10)
					c.now_ms = mir_offset + TIME_W'($urandom_range(0, 2));
				if ($urandom_range(99) < 3)
					await_results();
				send_command(c);
			end
		end
	endtask

	task automatic test_random_phases();
		int target;
		for (int p = 0; p < 6; p++) begin
			case (p)
				0: begin set_config(32'd0, 1'b0, 1'b1); idle_pct = 0; end
				1: begin set_config($urandom, 1'b1, 1'b1); idle_pct = 61; end
				2: begin set_config(32'h7FFF_FFFF, 1'b0, 1'b0); idle_pct = 33; end
				3: begin set_config($urandom, 1'b1, 1'b0); idle_pct = 0; end
				4: begin set_config(32'hFFFF_FFFF, 1'b0, 1'b1); idle_pct = 61; end
				default: begin
					set_config($urandom_range(0, 5000), 1'b1, 1'b1);
					idle_pct = 33;
				end
			endcase
			target = applied_items + PHASE_ITEMS;
			while (applied_items < target)
				run_burst();
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_table();
		test_reverse_interp();
		test_random_phases();
		drain_block();
		if (mismatch_count == 0 && expected_poses.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
